// File: hw/rtl/mdds_pkg.sv
package mdds_pkg;

  // number of low-order decimal digits that are summed
  localparam int DECIMAL_DIGITS = 10;

  // field widths
  localparam int VALUE_W  = 32;
  localparam int BEST_W   = 31;
  localparam int SUM_W    = 7;
  localparam int DIGIT_W  = 4;
  localparam int DCNT_W   = (DECIMAL_DIGITS > 1) ? $clog2(DECIMAL_DIGITS) : 1;

  // divide by ten through a reciprocal: q = (v * RECIP) >> SHIFT, exact for v < 2**32
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;
  localparam int          PROD_W      = BEST_W + 32;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage

// File: hw/rtl/max_decimal_digit_sum_tracker.sv
// for a positive value, each of the DECIMAL_DIGITS low-order digits takes a divide-by-ten multiply
//   step (ST_DIV) and then a remainder/accumulate step (ST_ACC), before ST_DONE loads the result
// an ending value (zero or negative) goes from acceptance straight to ST_DONE, then to out_valid
// a new transaction is accepted only in ST_IDLE, once the previous one has left ST_DONE
// a new transaction is accepted while the previous result still waits in the output register
// reset (synchronous, rst_n low) clears the tracker to zero and empties the output register
module max_decimal_digit_sum_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [mdds_pkg::VALUE_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mdds_pkg::SUM_W-1:0]    out_digit_sum,
  output logic [mdds_pkg::BEST_W-1:0]   out_best_value,
  output logic [mdds_pkg::SUM_W-1:0]    out_best_sum,
  output logic                          out_final_res
);

  mdds_pkg::state_t state_r, state_nxt;

  logic [mdds_pkg::BEST_W-1:0] work_r, work_nxt;
  logic [mdds_pkg::BEST_W-1:0] orig_r, orig_nxt;
  logic [mdds_pkg::BEST_W-1:0] quot_r, quot_nxt;
  logic [mdds_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [mdds_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        ends_r, ends_nxt;

  logic [mdds_pkg::BEST_W-1:0] tracked_value_r;
  logic [mdds_pkg::SUM_W-1:0]  tracked_sum_r;

  logic                        out_valid_r;
  logic [mdds_pkg::SUM_W-1:0]  out_digit_sum_r;
  logic [mdds_pkg::BEST_W-1:0] out_best_value_r;
  logic [mdds_pkg::SUM_W-1:0]  out_best_sum_r;
  logic                        out_final_r;

  logic                        in_take;
  logic                        in_ends;
  logic                        load;
  logic                        last_digit;
  logic [mdds_pkg::PROD_W-1:0] prod;
  logic [mdds_pkg::BEST_W-1:0] rem_full;
  logic [mdds_pkg::DIGIT_W-1:0] digit;
  logic                        better;

  // input decode
  assign in_ends    = in_value[mdds_pkg::VALUE_W-1] || (in_value == '0);
  assign last_digit = (cnt_r == mdds_pkg::DCNT_W'(mdds_pkg::DECIMAL_DIGITS - 1));

  // shared divide-by-ten unit
  assign prod     = mdds_pkg::PROD_W'(work_r) * mdds_pkg::PROD_W'(mdds_pkg::DIV10_RECIP);
  assign rem_full = work_r - ({quot_r[mdds_pkg::BEST_W-4:0], 3'b000}
                              + {quot_r[mdds_pkg::BEST_W-2:0], 1'b0});
  assign digit    = rem_full[mdds_pkg::DIGIT_W-1:0];
  assign better   = (sum_r > tracked_sum_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mdds_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_ends ? mdds_pkg::ST_DONE : mdds_pkg::ST_DIV;
        end
      end
      mdds_pkg::ST_DIV:  state_nxt = mdds_pkg::ST_ACC;
      mdds_pkg::ST_ACC:  state_nxt = last_digit ? mdds_pkg::ST_DONE : mdds_pkg::ST_DIV;
      mdds_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = mdds_pkg::ST_IDLE;
        end
      end
      default:           state_nxt = mdds_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    load     = 1'b0;
    case (state_r)
      mdds_pkg::ST_IDLE: in_stall = 1'b0;
      mdds_pkg::ST_DONE: load     = !out_valid_r || !out_stall;
      default: begin
        in_stall = 1'b1;
        load     = 1'b0;
      end
    endcase
  end

  assign in_take = in_valid && !in_stall;

  // datapath next values
  always_comb begin
    work_nxt = work_r;
    orig_nxt = orig_r;
    quot_nxt = quot_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    ends_nxt = ends_r;
    if (in_take) begin
      work_nxt = in_value[mdds_pkg::BEST_W-1:0];
      orig_nxt = in_value[mdds_pkg::BEST_W-1:0];
      sum_nxt  = '0;
      cnt_nxt  = '0;
      ends_nxt = in_ends;
    end else if (state_r == mdds_pkg::ST_DIV) begin
      quot_nxt = mdds_pkg::BEST_W'(prod >> mdds_pkg::DIV10_SHIFT);
    end else if (state_r == mdds_pkg::ST_ACC) begin
      work_nxt = quot_r;
      sum_nxt  = sum_r + mdds_pkg::SUM_W'(digit);
      if (!last_digit) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= mdds_pkg::ST_IDLE;
      cnt_r           <= '0;
      out_valid_r     <= 1'b0;
      tracked_value_r <= '0;
      tracked_sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
        if (ends_r) begin
          tracked_value_r <= '0;
          tracked_sum_r   <= '0;
        end else if (better) begin
          tracked_value_r <= orig_r;
          tracked_sum_r   <= sum_r;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    orig_r <= orig_nxt;
    quot_r <= quot_nxt;
    sum_r  <= sum_nxt;
    ends_r <= ends_nxt;
    if (load) begin
      out_final_r <= ends_r;
      if (ends_r) begin
        out_digit_sum_r  <= '0;
        out_best_value_r <= tracked_value_r;
        out_best_sum_r   <= tracked_sum_r;
      end else begin
        out_digit_sum_r  <= sum_r;
        out_best_value_r <= better ? orig_r : tracked_value_r;
        out_best_sum_r   <= better ? sum_r : tracked_sum_r;
      end
    end
  end

  // result transaction ports
  assign out_valid      = out_valid_r;
  assign out_digit_sum  = out_digit_sum_r;
  assign out_best_value = out_best_value_r;
  assign out_best_sum   = out_best_sum_r;
  assign out_final_res  = out_final_r;

  // final result carries no digit sum
  a_final_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_final_r |-> out_digit_sum_r == '0)
    else $error("final result with nonzero digit sum");

  // best sum never below the current item's sum
  a_best_ge_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_final_r |-> out_best_sum_r >= out_digit_sum_r)
    else $error("best sum below item digit sum");

  // ending transaction clears the tracker
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load && ends_r |=> tracked_sum_r == '0 && tracked_value_r == '0)
    else $error("tracker not cleared after ending transaction");

  // tracked best never decreases within a set
  a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    load && !ends_r |=> tracked_sum_r >= $past(tracked_sum_r))
    else $error("tracked sum decreased");

  // digit counter stays in range
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mdds_pkg::DCNT_W'(mdds_pkg::DECIMAL_DIGITS - 1))
    else $error("digit counter out of range");

endmodule
